// ----- hw/rtl/rrq_pkg.sv -----
// Shared constants for the round-robin thread run queue.
// Action and status codes, id width and default queue depth.
// No dependencies.
package rrq_pkg;

	localparam int ID_W            = 16;
	localparam int DEF_MAX_THREADS = 16;

	// action codes of an input item
	localparam logic [1:0] ACT_ADMIT  = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_NEXT   = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	// status codes of a result item
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		SEQ_IDLE   = 6'b000001,
		SEQ_FETCH  = 6'b000010,
		SEQ_TAKE   = 6'b000100,
		SEQ_SEARCH = 6'b001000,
		SEQ_SHIFT  = 6'b010000,
		SEQ_REPLY  = 6'b100000
	} seq_state_t;

endpackage

// ----- hw/rtl/rrq_if.sv -----
// Valid/ready channels of the run queue: request and response.
// Depends on rrq_pkg for the id width and default depth.
interface rrq_req_if;
	import rrq_pkg::*;
	logic            valid;
	logic            ready;
	logic [1:0]      action;
	logic [ID_W-1:0] thread_id;

	modport source (output valid, action, thread_id, input ready);
	modport sink   (input valid, action, thread_id, output ready);
endinterface

interface rrq_rsp_if #(
	parameter int MAX_THREADS = rrq_pkg::DEF_MAX_THREADS
);
	import rrq_pkg::*;
	localparam int OCC_W = $clog2(MAX_THREADS + 1);
	logic             valid;
	logic             ready;
	logic [ID_W-1:0]  chosen_id;
	logic [1:0]       status;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, chosen_id, status, occupancy, input ready);
	modport sink   (input valid, chosen_id, status, occupancy, output ready);
endinterface

// ----- hw/rtl/round_robin_thread_queue_unit.sv -----
// Round-robin run queue of thread ids: ring store, search and shift sequencer.
// Depends on rrq_pkg and the rrq_req_if / rrq_rsp_if channels.
//
//   channel  dir  payload                          handshake
//   req      in   action, thread_id                valid/ready
//   rsp      out  chosen_id, status, occupancy     valid/ready
//
// Admit, unknown actions and remove or next on an empty queue go straight to the
// reply state; next reads the current slot through fetch and take. Remove with a match
// searches at one compare a cycle, then closes the gap behind the match with one read
// and one write a cycle. Remove of an id not queued searches every entry, then replies.
// Reset clears the count and current position; the ring itself is not cleared.
// A stalled response holds in its register; req is ready again once the
// result has moved there.
module round_robin_thread_queue_unit #(
	parameter int MAX_THREADS = rrq_pkg::DEF_MAX_THREADS
) (
	input  logic          clk,
	input  logic          arst_n,
	rrq_req_if.sink       req,
	rrq_rsp_if.source     rsp
);
	import rrq_pkg::*;

	localparam int IW = $clog2(MAX_THREADS);
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_THREADS);

	logic [ID_W-1:0] ring_mem [MAX_THREADS];

	seq_state_t      state_q;
	logic [CW-1:0]   cnt_q;
	logic [IW-1:0]   cur_q;
	logic [ID_W-1:0] id_q;
	logic [CW-1:0]   iss_q;
	logic [IW-1:0]   pos_q;
	logic            chk_vld_s1;
	logic [IW-1:0]   chk_idx_s1;
	logic [ID_W-1:0] rd_data_s1;
	logic [ID_W-1:0] res_id_q;
	logic [1:0]      res_st_q;

	logic            out_vld_q;
	logic [ID_W-1:0] out_id_q;
	logic [1:0]      out_st_q;
	logic [CW-1:0]   out_occ_q;

	logic            acc;
	logic            issue;
	logic [IW-1:0]   rd_addr;
	logic            mem_we;
	logic [IW-1:0]   mem_wa;
	logic [ID_W-1:0] mem_wd;
	logic            match;
	logic            rsp_load;
	logic [CW-1:0]   cnt_dec;

	assign req.ready = (state_q == SEQ_IDLE);
	assign acc       = req.valid && req.ready;
	assign issue     = ((state_q == SEQ_SEARCH) || (state_q == SEQ_SHIFT)) && (iss_q < cnt_q);
	assign rd_addr   = issue ? iss_q[IW-1:0] : cur_q;
	assign match     = (state_q == SEQ_SEARCH) && chk_vld_s1 && (rd_data_s1 == id_q);
	assign rsp_load  = (state_q == SEQ_REPLY) && (!out_vld_q || rsp.ready);
	assign cnt_dec   = cnt_q - CW'(1);

	// one write port: shift moves take it, else an admit appends
	always_comb begin
		mem_we = 1'b0;
		mem_wa = chk_idx_s1 - IW'(1);
		mem_wd = rd_data_s1;
		if ((state_q == SEQ_SHIFT) && chk_vld_s1) begin
			mem_we = 1'b1;
		end else if (acc && (req.action == ACT_ADMIT) && (cnt_q != CNT_MAX)) begin
			mem_we = 1'b1;
			mem_wa = cnt_q[IW-1:0];
			mem_wd = req.thread_id;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			cnt_q      <= '0;
			cur_q      <= '0;
			iss_q      <= '0;
			pos_q      <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_idx_s1 <= iss_q[IW-1:0];
			if (match) begin
				// drop reads still in flight, restart at the slot after the match
				chk_vld_s1 <= 1'b0;
				iss_q      <= CW'(chk_idx_s1) + CW'(1);
			end else begin
				// read pipeline tag: valid is set in the cycle after each issued read
				chk_vld_s1 <= issue;
				if (issue) begin
					iss_q <= iss_q + CW'(1);
				end
			end
			case (state_q)
				SEQ_IDLE: begin
					if (acc) begin
						id_q     <= req.thread_id;
						res_id_q <= '0;
						res_st_q <= STAT_OK;
						state_q  <= SEQ_REPLY;
						case (req.action)
							ACT_ADMIT: begin
								if (cnt_q == CNT_MAX) begin
									res_st_q <= STAT_FULL;
								end else begin
									if (cnt_q == '0) begin
										cur_q <= '0;
									end
									cnt_q <= cnt_q + CW'(1);
								end
							end
							ACT_REMOVE: begin
								if (cnt_q == '0) begin
									res_st_q <= STAT_EMPTY;
								end else begin
									iss_q   <= '0;
									state_q <= SEQ_SEARCH;
								end
							end
							ACT_NEXT: begin
								if (cnt_q == '0) begin
									res_st_q <= STAT_EMPTY;
								end else begin
									state_q <= SEQ_FETCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				SEQ_FETCH: begin
					state_q <= SEQ_TAKE;
				end
				SEQ_TAKE: begin
					res_id_q <= rd_data_s1;
					if ((CW'(cur_q) + CW'(1)) >= cnt_q) begin
						cur_q <= '0;
					end else begin
						cur_q <= cur_q + IW'(1);
					end
					state_q <= SEQ_REPLY;
				end
				SEQ_SEARCH: begin
					if (match) begin
						pos_q   <= chk_idx_s1;
						state_q <= SEQ_SHIFT;
					end else if (!chk_vld_s1 && (iss_q == cnt_q)) begin
						res_st_q <= STAT_NOT_FOUND;
						state_q  <= SEQ_REPLY;
					end
				end
				SEQ_SHIFT: begin
					if (!chk_vld_s1 && (iss_q == cnt_q)) begin
						cnt_q <= cnt_dec;
						if (cnt_dec == '0) begin
							cur_q <= '0;
						end else if (pos_q < cur_q) begin
							cur_q <= cur_q - IW'(1);
						end else if (CW'(cur_q) >= cnt_dec) begin
							cur_q <= '0;
						end
						state_q <= SEQ_REPLY;
					end
				end
				SEQ_REPLY: begin
					if (rsp_load) begin
						state_q <= SEQ_IDLE;
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rsp_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_id_q  <= res_id_q;
			out_st_q  <= res_st_q;
			out_occ_q <= cnt_q;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.chosen_id = out_id_q;
	assign rsp.status    = out_st_q;
	assign rsp.occupancy = out_occ_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above queue depth");

	a_cur_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 && cur_q == '0) || (CW'(cur_q) < cnt_q))
		else $error("current position outside the ring");

	a_admit_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.action == ACT_ADMIT && cnt_q != CNT_MAX)
		|=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("admit did not append one entry");

	a_reply_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_REPLY && !rsp_load) |=> (state_q == SEQ_REPLY))
		else $error("pending result dropped before the response register took it");

endmodule

// ----- tb/tb_round_robin_thread_queue_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_thread_queue_unit: directed and random
// admit/remove/next items, with a run-queue predictor and bursty valid/ready traffic.
// Depends on rrq_pkg, rrq_req_if / rrq_rsp_if and the unit itself.
module tb_round_robin_thread_queue_unit;
	import rrq_pkg::*;

	localparam int MAX_T      = DEF_MAX_THREADS;
	localparam int OCC_W      = $clog2(MAX_T + 1);
	localparam int RAND_ITEMS = 600;

	// traffic mixes of the random part
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_BLEND = 2;

	typedef struct packed {
		logic [1:0]      action;
		logic [ID_W-1:0] thread_id;
	} sched_req_t;

	typedef struct packed {
		logic [ID_W-1:0]  chosen_id;
		logic [1:0]       status;
		logic [OCC_W-1:0] occupancy;
	} sched_reply_t;

	logic clk;
	logic arst_n;

	rrq_req_if                        req_ch ();
	rrq_rsp_if #(.MAX_THREADS(MAX_T)) rsp_ch ();

	round_robin_thread_queue_unit #(.MAX_THREADS(MAX_T)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sched_req_t   pending_requests [$];
	sched_reply_t expected_replies [$];
	logic [ID_W-1:0] stim_ids [$];      // what the queue holds, in stimulus order

	// predicted run queue
	logic [ID_W-1:0] run_ring [MAX_T];
	int unsigned     run_count;
	int unsigned     run_cursor;

	int errors;
	int n_sent;
	int n_checked;
	int n_full;
	int n_empty;
	int n_not_found;

	always #6 clk = ~clk;

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.action    = ACT_ADMIT;
		req_ch.thread_id = '0;
		rsp_ch.ready     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH %s: got %0h want %0h at %0t ns", what, got, want, $realtime);
	endtask

	// Advance the predicted queue by one item and return the reply it causes.
	task automatic schedule_step(input logic [1:0] act, input logic [ID_W-1:0] tid,
			output sched_reply_t reply);
		int unsigned pos;
		int unsigned k;
		bit          hit;
		reply.chosen_id = '0;
		reply.status    = STAT_OK;
		case (act)
			ACT_ADMIT: begin
				if (run_count >= MAX_T) begin
					reply.status = STAT_FULL;
				end else begin
					if (run_count == 0) run_cursor = 0;
					run_ring[run_count] = tid;
					run_count++;
				end
			end
			ACT_REMOVE: begin
				if (run_count == 0) begin
					reply.status = STAT_EMPTY;
				end else begin
					hit = 1'b0;
					pos = 0;
					for (k = 0; k < run_count; k++) begin
						if (!hit && run_ring[k] == tid) begin
							hit = 1'b1;
							pos = k;
						end
					end
					if (!hit) begin
						reply.status = STAT_NOT_FOUND;
					end else begin
						// close the gap
						for (k = pos; k + 1 < run_count; k++)
							run_ring[k] = run_ring[k + 1];
						run_count--;
						if (run_count == 0)
							run_cursor = 0;
						else if (pos < run_cursor)
							run_cursor--;
						else if (run_cursor >= run_count)
							run_cursor = 0;
					end
				end
			end
			ACT_NEXT: begin
				if (run_count == 0) begin
					reply.status = STAT_EMPTY;
				end else begin
					reply.chosen_id = run_ring[run_cursor];
					run_cursor++;
					if (run_cursor >= run_count) run_cursor = 0;
				end
			end
			default: ;
		endcase
		reply.occupancy = OCC_W'(run_count);
		case (reply.status)
			STAT_FULL:      n_full++;
			STAT_EMPTY:     n_empty++;
			STAT_NOT_FOUND: n_not_found++;
			default: ;
		endcase
	endtask

	// Queue an item and track the queue contents so removes can hit real ids.
	task automatic push_request(input logic [1:0] act, input logic [ID_W-1:0] tid);
		sched_req_t item;
		int         k;
		int         at;
		item.action    = act;
		item.thread_id = tid;
		pending_requests.push_back(item);
		if (act == ACT_ADMIT && stim_ids.size() < MAX_T) begin
			stim_ids.push_back(tid);
		end else if (act == ACT_REMOVE) begin
			at = -1;
			for (k = 0; k < stim_ids.size(); k++)
				if (at < 0 && stim_ids[k] == tid) at = k;
			if (at >= 0) stim_ids.delete(at);
		end
	endtask

	// Small pool for duplicates, the extremes, and full-range ids.
	function automatic logic [ID_W-1:0] pick_id();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40) return ID_W'($urandom_range(7));
		if (sel < 45) return '0;
		if (sel < 50) return '1;
		return ID_W'($urandom);
	endfunction

	// Driver: bursts of items separated by random gaps; hold while not accepted.
	sched_req_t  drive_item;
	sched_reply_t drive_reply;
	int          gap_left;
	int          burst_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.action    <= ACT_ADMIT;
			req_ch.thread_id <= '0;
			gap_left         <= 0;
			burst_left       <= 1;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				schedule_step(req_ch.action, req_ch.thread_id, drive_reply);
				expected_replies.push_back(drive_reply);
				n_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					req_ch.valid <= 1'b0;
					gap_left     <= gap_left - 1;
				end else if (pending_requests.size() > 0) begin
					drive_item        = pending_requests.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.action    <= drive_item.action;
					req_ch.thread_id <= drive_item.thread_id;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each reply; ready follows a rotating stall pattern.
	sched_reply_t want_reply;
	logic [7:0]   stall_bits;
	int           stall_tick;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_bits   <= 8'hFF;
			stall_tick   <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("reply with no item outstanding", rsp_ch.status, 0);
				end else begin
					want_reply = expected_replies.pop_front();
					n_checked++;
					if (rsp_ch.chosen_id !== want_reply.chosen_id)
						report_mismatch("chosen_id", rsp_ch.chosen_id, want_reply.chosen_id);
					if (rsp_ch.status !== want_reply.status)
						report_mismatch("status", rsp_ch.status, want_reply.status);
					if (rsp_ch.occupancy !== want_reply.occupancy)
						report_mismatch("occupancy", rsp_ch.occupancy, want_reply.occupancy);
				end
			end
			if (stall_tick == 63) begin
				// stall-free window now and then, otherwise a fresh pattern
				stall_bits <= ($urandom_range(3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
				stall_tick <= 0;
			end else begin
				stall_bits <= {stall_bits[0], stall_bits[7:1]};
				stall_tick <= stall_tick + 1;
			end
			rsp_ch.ready <= stall_bits[0];
		end
	end

	initial begin
		int mix;
		int mix_left;
		int roll;
		int n;
		logic [1:0] act;
		logic [ID_W-1:0] tid;

		errors      = 0;
		n_sent      = 0;
		n_checked   = 0;
		n_full      = 0;
		n_empty     = 0;
		n_not_found = 0;
		run_count   = 0;
		run_cursor  = 0;

		// empty queue, unused action code
		push_request(ACT_NEXT, 16'h1357);
		push_request(ACT_REMOVE, 16'h5A5A);
		push_request(ACT_NOP, 16'hFFFF);
		// extremes and a duplicate
		push_request(ACT_ADMIT, 16'hFFFF);
		push_request(ACT_ADMIT, 16'h0000);
		push_request(ACT_ADMIT, 16'h0000);
		push_request(ACT_NEXT, 16'h0000);
		// remove the current entry: only the first duplicate goes
		push_request(ACT_REMOVE, 16'h0000);
		push_request(ACT_REMOVE, 16'hABCD);
		push_request(ACT_NEXT, 16'hFFFF);   // wraps after this
		push_request(ACT_NEXT, 16'h0000);
		// remove an entry before the current one, then drain to empty
		push_request(ACT_REMOVE, 16'hFFFF);
		push_request(ACT_REMOVE, 16'h0000);
		// remove the current entry when it is last: current wraps
		push_request(ACT_ADMIT, 16'h0001);
		push_request(ACT_ADMIT, 16'h8000);
		push_request(ACT_NEXT, 16'h2468);
		push_request(ACT_REMOVE, 16'h8000);
		push_request(ACT_NEXT, 16'h0000);
		push_request(ACT_NOP, 16'h0000);

		mix      = MIX_FILL;
		mix_left = $urandom_range(30, 60);
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (mix_left == 0) begin
				mix      = $urandom_range(MIX_BLEND);
				mix_left = $urandom_range(30, 60);
			end
			mix_left--;
			roll = $urandom_range(99);
			case (mix)
				MIX_FILL:  act = (roll < 75) ? ACT_ADMIT : (roll < 90) ? ACT_REMOVE :
						(roll < 98) ? ACT_NEXT : ACT_NOP;
				MIX_DRAIN: act = (roll < 15) ? ACT_ADMIT : (roll < 70) ? ACT_REMOVE :
						(roll < 95) ? ACT_NEXT : ACT_NOP;
				default:   act = (roll < 35) ? ACT_ADMIT : (roll < 65) ? ACT_REMOVE :
						(roll < 95) ? ACT_NEXT : ACT_NOP;
			endcase
			tid = pick_id();
			// most removes name an id that is queued
			if (act == ACT_REMOVE && stim_ids.size() > 0 && $urandom_range(99) < 80)
				tid = stim_ids[$urandom_range(stim_ids.size() - 1)];
			push_request(act, tid);
		end

		while (pending_requests.size() != 0 || req_ch.valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d items, checked %0d replies", n_sent, n_checked);
		$display("Saw %0d full, %0d empty and %0d not-found replies", n_full, n_empty,
			n_not_found);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d replies outstanding", expected_replies.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
